/* src/ofn_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofn_pkg: shared types and constants for the orthonormal frame block
// Holds the component type, register widths and saturation limits that the
// frame datapath and its normalization units share.
// ----------------------------------------------------------------------------
package ofn_pkg;

  localparam int unsigned CompW = 16;
  localparam int unsigned ThrW  = 29;
  localparam int unsigned Lanes = 3;

  typedef logic signed [CompW-1:0] comp_t;

  localparam logic [ThrW-1:0] ThrReset = 29'd16;
  localparam comp_t CompMax = 16'sh7FFF;
  localparam comp_t CompMin = 16'sh8000;

  // Magnitude of a signed component; the most negative code maps to 32768.
  function automatic logic [CompW-1:0] comp_mag(comp_t v);
    comp_mag = v[CompW-1] ? CompW'(-v) : CompW'(v);
  endfunction

endpackage

/* src/ofn_isqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofn_isqrt: pipelined integer square root
// Computes floor(sqrt(rad)) one result bit per register stage and carries a
// side-band word alongside so that callers keep their data aligned.
// ----------------------------------------------------------------------------
module ofn_isqrt #(
  parameter int unsigned W  = 34,
  parameter int unsigned PW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [W-1:0]    rad_i,
  input  logic [PW-1:0]   side_i,
  output logic            valid_o,
  output logic [W/2-1:0]  root_o,
  output logic [PW-1:0]   side_o
);

  localparam int unsigned Steps = W / 2;

  logic [W-1:0]  rem_in  [Steps];
  logic [W-1:0]  res_in  [Steps];
  logic [PW-1:0] side_in [Steps];
  logic          vld_in  [Steps];
  logic [W-1:0]  rem_out [Steps];
  logic [W-1:0]  res_out [Steps];
  logic [PW-1:0] side_out[Steps];
  logic          vld_out [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam int unsigned Sh = W - 2 - 2 * k;

    logic [W-1:0]  one_bit;
    logic [W:0]    trial;
    logic [W-1:0]  rem_d, res_d, rem_q, res_q;
    logic [PW-1:0] side_q;
    logic          valid_q;

    // Stage inputs come from the ports or from the previous stage.
    if (k == 0) begin : g_first
      assign rem_in[k]  = rad_i;
      assign res_in[k]  = '0;
      assign side_in[k] = side_i;
      assign vld_in[k]  = valid_i;
    end else begin : g_next
      assign rem_in[k]  = rem_out[k-1];
      assign res_in[k]  = res_out[k-1];
      assign side_in[k] = side_out[k-1];
      assign vld_in[k]  = vld_out[k-1];
    end

    assign one_bit = W'(1) << Sh;

    // One digit of the restoring square root.
    always_comb begin
      trial = {1'b0, res_in[k]} + {1'b0, one_bit};
      if ({1'b0, rem_in[k]} >= trial) begin
        rem_d = rem_in[k] - trial[W-1:0];
        res_d = (res_in[k] >> 1) + one_bit;
      end else begin
        rem_d = rem_in[k];
        res_d = res_in[k] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q <= 1'b0;
      end else if (en_i) begin
        valid_q <= vld_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= rem_d;
        res_q  <= res_d;
        side_q <= side_in[k];
      end
    end

    assign rem_out[k]  = rem_q;
    assign res_out[k]  = res_q;
    assign side_out[k] = side_q;
    assign vld_out[k]  = valid_q;
  end

  assign valid_o = vld_out[Steps-1];
  assign root_o  = res_out[Steps-1][Steps-1:0];
  assign side_o  = side_out[Steps-1];

endmodule

/* src/ofn_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofn_div: pipelined three-lane divider with a shared divisor
// Restoring long division, one quotient bit per register stage. The caller
// guarantees that every quotient fits in QW bits.
// ----------------------------------------------------------------------------
module ofn_div #(
  parameter int unsigned DW = 31,
  parameter int unsigned RW = 17,
  parameter int unsigned QW = 15,
  parameter int unsigned PW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] num_i [3],
  input  logic [RW-1:0] den_i,
  input  logic [PW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o [3],
  output logic [PW-1:0] side_o
);

  localparam int unsigned XW = DW + RW;

  logic [DW-1:0] rem_in  [QW][3];
  logic [QW-1:0] quo_in  [QW][3];
  logic [RW-1:0] den_in  [QW];
  logic [PW-1:0] side_in [QW];
  logic          vld_in  [QW];
  logic [DW-1:0] rem_out [QW][3];
  logic [QW-1:0] quo_out [QW][3];
  logic [RW-1:0] den_out [QW];
  logic [PW-1:0] side_out[QW];
  logic          vld_out [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int unsigned Sh = QW - 1 - k;

    logic [XW-1:0] trial;
    logic [DW-1:0] rem_d [3];
    logic [QW-1:0] quo_d [3];
    logic [DW-1:0] rem_q [3];
    logic [QW-1:0] quo_q [3];
    logic [RW-1:0] den_q;
    logic [PW-1:0] side_q;
    logic          valid_q;

    if (k == 0) begin : g_first
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_in[k][l] = num_i[l];
        assign quo_in[k][l] = '0;
      end
      assign den_in[k]  = den_i;
      assign side_in[k] = side_i;
      assign vld_in[k]  = valid_i;
    end else begin : g_next
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_in[k][l] = rem_out[k-1][l];
        assign quo_in[k][l] = quo_out[k-1][l];
      end
      assign den_in[k]  = den_out[k-1];
      assign side_in[k] = side_out[k-1];
      assign vld_in[k]  = vld_out[k-1];
    end

    assign trial = XW'(den_in[k]) << Sh;

    // Trial subtraction of the shifted divisor in each lane.
    always_comb begin
      for (int l = 0; l < 3; l++) begin
        if (XW'(rem_in[k][l]) >= trial) begin
          rem_d[l] = rem_in[k][l] - trial[DW-1:0];
          quo_d[l] = {quo_in[k][l][QW-2:0], 1'b1};
        end else begin
          rem_d[l] = rem_in[k][l];
          quo_d[l] = {quo_in[k][l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q <= 1'b0;
      end else if (en_i) begin
        valid_q <= vld_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= rem_d;
        quo_q  <= quo_d;
        den_q  <= den_in[k];
        side_q <= side_in[k];
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_out
      assign rem_out[k][l] = rem_q[l];
      assign quo_out[k][l] = quo_q[l];
    end
    assign den_out[k]  = den_q;
    assign side_out[k] = side_q;
    assign vld_out[k]  = valid_q;
  end

  assign valid_o = vld_out[QW-1];
  assign side_o  = side_out[QW-1];
  for (genvar l = 0; l < 3; l++) begin : g_quo
    assign quo_o[l] = quo_out[QW-1][l];
  end

endmodule

/* src/ofn_unit3.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofn_unit3: pipelined normalization of a 3-vector
// Squares and sums the component magnitudes, takes the integer square root,
// divides each component by it with rounding and saturates to Q1.FRAC.
// A zero length gives a zero vector.
// ----------------------------------------------------------------------------
module ofn_unit3 #(
  parameter int unsigned MW = 16,
  parameter int unsigned F  = 14,
  parameter int unsigned PW = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [MW-1:0]  mag_i [3],
  input  logic [2:0]     neg_i,
  input  logic [PW-1:0]  side_i,
  output logic           valid_o,
  output ofn_pkg::comp_t comp_o [3],
  output logic [PW-1:0]  side_o
);

  import ofn_pkg::*;

  localparam int unsigned SqW  = 2 * MW;
  localparam int unsigned SumW = 2 * MW + 2;
  localparam int unsigned RW   = MW + 1;
  localparam int unsigned DW   = MW + F + 1;
  localparam int unsigned QW   = F + 1;
  localparam int unsigned IPW  = PW + 3 + 3 * MW;
  localparam int unsigned DPW  = PW + 4;
  localparam int unsigned EW   = (QW > 17) ? QW : 17;

  // Stage A: squares of the magnitudes.
  logic           a_valid_q;
  logic [SqW-1:0] a_sq_q  [3];
  logic [MW-1:0]  a_mag_q [3];
  logic [2:0]     a_neg_q;
  logic [PW-1:0]  a_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 3; l++) begin
        a_sq_q[l]  <= SqW'(mag_i[l]) * SqW'(mag_i[l]);
        a_mag_q[l] <= mag_i[l];
      end
      a_neg_q  <= neg_i;
      a_side_q <= side_i;
    end
  end

  // Stage B: sum of squares.
  logic            b_valid_q;
  logic [SumW-1:0] b_sum_q;
  logic [MW-1:0]   b_mag_q [3];
  logic [2:0]      b_neg_q;
  logic [PW-1:0]   b_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_sum_q  <= SumW'(a_sq_q[0]) + SumW'(a_sq_q[1]) + SumW'(a_sq_q[2]);
      b_mag_q  <= a_mag_q;
      b_neg_q  <= a_neg_q;
      b_side_q <= a_side_q;
    end
  end

  // Square root of the squared length.
  logic           s_valid;
  logic [RW-1:0]  s_root;
  logic [IPW-1:0] s_side;
  logic [MW-1:0]  s_mag [3];
  logic [2:0]     s_neg;
  logic [PW-1:0]  s_outer;

  ofn_isqrt #(
    .W  (SumW),
    .PW (IPW)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (b_valid_q),
    .rad_i   (b_sum_q),
    .side_i  ({b_side_q, b_neg_q, b_mag_q[2], b_mag_q[1], b_mag_q[0]}),
    .valid_o (s_valid),
    .root_o  (s_root),
    .side_o  (s_side)
  );

  assign {s_outer, s_neg, s_mag[2], s_mag[1], s_mag[0]} = s_side;

  // Dividends carry half the divisor for round-to-nearest.
  logic [DW-1:0] num [3];
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      num[l] = (DW'(s_mag[l]) << F) + DW'(s_root >> 1);
    end
  end

  logic           d_valid;
  logic [QW-1:0]  d_quo [3];
  logic [DPW-1:0] d_side;
  logic [PW-1:0]  d_outer;
  logic [2:0]     d_neg;
  logic           d_zero;

  ofn_div #(
    .DW (DW),
    .RW (RW),
    .QW (QW),
    .PW (DPW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (s_valid),
    .num_i   (num),
    .den_i   (s_root),
    .side_i  ({s_outer, s_neg, (s_root == '0)}),
    .valid_o (d_valid),
    .quo_o   (d_quo),
    .side_o  (d_side)
  );

  assign {d_outer, d_neg, d_zero} = d_side;

  // Final stage: apply sign, saturate and force zero for a zero length.
  comp_t         comp_d [3];
  logic [EW-1:0] qe     [3];
  logic [EW-1:0] qn     [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      qe[l] = EW'(d_quo[l]);
      qn[l] = EW'(0) - qe[l];
      if (d_zero) begin
        comp_d[l] = '0;
      end else if (d_neg[l]) begin
        comp_d[l] = (qe[l] > EW'(32768)) ? CompMin : comp_t'(qn[l][CompW-1:0]);
      end else begin
        comp_d[l] = (qe[l] > EW'(32767)) ? CompMax : comp_t'(qe[l][CompW-1:0]);
      end
    end
  end

  logic          f_valid_q;
  comp_t         f_comp_q [3];
  logic [PW-1:0] f_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (en_i) begin
      f_valid_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_comp_q <= comp_d;
      f_side_q <= d_outer;
    end
  end

  assign valid_o = f_valid_q;
  assign comp_o  = f_comp_q;
  assign side_o  = f_side_q;

endmodule

/* src/orthonormal_frame_from_normal.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orthonormal_frame_from_normal: 3x3 orthonormal frame from a unit normal
// Builds column 0 (the normal), a normalized tangent and a normalized
// normal-cross-tangent, in signed Q1.FRAC_BITS fixed point.
//
// Usage:
//   The input channel (in_valid_i / in_ready_o) takes one normal per
//   transfer; the output channel (out_valid_o / out_ready_i) returns one
//   frame and the fallback flag per transfer, in input order.
//   The config channel writes small_sq_threshold (reset value 16); it is
//   always ready. The user writes it only while the block is idle; the
//   block itself does not enforce this. Throughput is one item per cycle
//   when the receiver does not stall. Latency comes mostly from the two
//   square-root and divider pipelines that produce one result bit per stage.
//   Reset clears all valid bits and loads the threshold. When the receiver
//   stalls, the result waits in the output register and the pipeline keeps
//   accepting until its last stage holds an item; then the whole pipeline
//   holds and in_ready_o drops, with no item lost or repeated.
// ----------------------------------------------------------------------------
module orthonormal_frame_from_normal #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ofn_pkg::ThrW-1:0]    small_sq_threshold_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  ofn_pkg::comp_t              normal_x_i,
  input  ofn_pkg::comp_t              normal_y_i,
  input  ofn_pkg::comp_t              normal_z_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output ofn_pkg::comp_t              col0_x_o,
  output ofn_pkg::comp_t              col0_y_o,
  output ofn_pkg::comp_t              col0_z_o,
  output ofn_pkg::comp_t              col1_x_o,
  output ofn_pkg::comp_t              col1_y_o,
  output ofn_pkg::comp_t              col1_z_o,
  output ofn_pkg::comp_t              col2_x_o,
  output ofn_pkg::comp_t              col2_y_o,
  output ofn_pkg::comp_t              col2_z_o,
  output logic                        fallback_used_o
);

  import ofn_pkg::*;

  localparam int unsigned CMW  = 34 - FRAC_BITS;
  localparam int unsigned NW   = 3 * CompW;
  localparam int unsigned S1W  = NW + 1;
  localparam int unsigned S2W  = 2 * NW + 1;

  logic adv;
  logic out_load;

  // Threshold register.
  logic [ThrW-1:0] thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_valid_i) begin
      thr_q <= small_sq_threshold_i;
    end
  end

  // Stage 0: capture the normal and square its x and y magnitudes.
  logic        s0_valid_q;
  comp_t       s0_n_q [3];
  logic [31:0] s0_sqx_q, s0_sqy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (adv) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_n_q[0] <= normal_x_i;
      s0_n_q[1] <= normal_y_i;
      s0_n_q[2] <= normal_z_i;
      s0_sqx_q  <= 32'(comp_mag(normal_x_i)) * 32'(comp_mag(normal_x_i));
      s0_sqy_q  <= 32'(comp_mag(normal_y_i)) * 32'(comp_mag(normal_y_i));
    end
  end

  // Stage 1: threshold test and tangent choice.
  logic             fb_d;
  logic [CompW-1:0] tmag_d [3];
  logic [2:0]       tneg_d;

  always_comb begin
    fb_d = ({1'b0, s0_sqx_q} + {1'b0, s0_sqy_q}) < 33'(thr_q);
    if (fb_d) begin
      tmag_d[0] = '0;
      tmag_d[1] = comp_mag(s0_n_q[2]);
      tmag_d[2] = comp_mag(s0_n_q[1]);
      tneg_d    = {s0_n_q[1][CompW-1],
                   (!s0_n_q[2][CompW-1] && (s0_n_q[2] != '0)), 1'b0};
    end else begin
      tmag_d[0] = comp_mag(s0_n_q[1]);
      tmag_d[1] = comp_mag(s0_n_q[0]);
      tmag_d[2] = '0;
      tneg_d    = {1'b0, s0_n_q[0][CompW-1],
                   (!s0_n_q[1][CompW-1] && (s0_n_q[1] != '0))};
    end
  end

  logic             s1_valid_q;
  logic [CompW-1:0] s1_tmag_q [3];
  logic [2:0]       s1_tneg_q;
  comp_t            s1_n_q [3];
  logic             s1_fb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_tmag_q <= tmag_d;
      s1_tneg_q <= tneg_d;
      s1_n_q    <= s0_n_q;
      s1_fb_q   <= fb_d;
    end
  end

  // Normalize the tangent.
  logic           u1_valid;
  comp_t          u1_t [3];
  logic [S1W-1:0] u1_side;
  comp_t          u1_n [3];
  logic           u1_fb;

  ofn_unit3 #(
    .MW (CompW),
    .F  (FRAC_BITS),
    .PW (S1W)
  ) u_tangent (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s1_valid_q),
    .mag_i   (s1_tmag_q),
    .neg_i   (s1_tneg_q),
    .side_i  ({s1_fb_q, s1_n_q[2], s1_n_q[1], s1_n_q[0]}),
    .valid_o (u1_valid),
    .comp_o  (u1_t),
    .side_o  (u1_side)
  );

  assign {u1_fb, u1_n[2], u1_n[1], u1_n[0]} = u1_side;

  // Cross stage 1: the six partial products of n x t.
  logic               c1_valid_q;
  logic signed [31:0] c1_p_q [6];
  comp_t              c1_n_q [3];
  comp_t              c1_t_q [3];
  logic               c1_fb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_valid_q <= 1'b0;
    end else if (adv) begin
      c1_valid_q <= u1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_p_q[0] <= u1_n[1] * u1_t[2];
      c1_p_q[1] <= u1_n[2] * u1_t[1];
      c1_p_q[2] <= u1_n[2] * u1_t[0];
      c1_p_q[3] <= u1_n[0] * u1_t[2];
      c1_p_q[4] <= u1_n[0] * u1_t[1];
      c1_p_q[5] <= u1_n[1] * u1_t[0];
      c1_n_q    <= u1_n;
      c1_t_q    <= u1_t;
      c1_fb_q   <= u1_fb;
    end
  end

  // Cross stage 2: differences, then round magnitudes half away from zero.
  logic signed [32:0] cdiff [3];
  logic [32:0]        cmagx [3];
  logic [33:0]        crnd  [3];
  logic [CMW-1:0]     cmag_d [3];
  logic [2:0]         cneg_d;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      cdiff[l]  = 33'(c1_p_q[2*l]) - 33'(c1_p_q[2*l+1]);
      cmagx[l]  = cdiff[l][32] ? 33'(-cdiff[l]) : 33'(cdiff[l]);
      crnd[l]   = 34'(cmagx[l]) + (34'(1) << (FRAC_BITS - 1));
      cmag_d[l] = crnd[l][33:FRAC_BITS];
      cneg_d[l] = cdiff[l][32];
    end
  end

  logic           c2_valid_q;
  logic [CMW-1:0] c2_mag_q [3];
  logic [2:0]     c2_neg_q;
  comp_t          c2_n_q [3];
  comp_t          c2_t_q [3];
  logic           c2_fb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c2_valid_q <= 1'b0;
    end else if (adv) begin
      c2_valid_q <= c1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c2_mag_q <= cmag_d;
      c2_neg_q <= cneg_d;
      c2_n_q   <= c1_n_q;
      c2_t_q   <= c1_t_q;
      c2_fb_q  <= c1_fb_q;
    end
  end

  // Normalize the cross product.
  logic           u2_valid;
  comp_t          u2_c [3];
  logic [S2W-1:0] u2_side;
  comp_t          u2_n [3];
  comp_t          u2_t [3];
  logic           u2_fb;

  ofn_unit3 #(
    .MW (CMW),
    .F  (FRAC_BITS),
    .PW (S2W)
  ) u_binormal (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (c2_valid_q),
    .mag_i   (c2_mag_q),
    .neg_i   (c2_neg_q),
    .side_i  ({c2_fb_q, c2_t_q[2], c2_t_q[1], c2_t_q[0],
               c2_n_q[2], c2_n_q[1], c2_n_q[0]}),
    .valid_o (u2_valid),
    .comp_o  (u2_c),
    .side_o  (u2_side)
  );

  assign {u2_fb, u2_t[2], u2_t[1], u2_t[0], u2_n[2], u2_n[1], u2_n[0]} = u2_side;

  // Output register; the pipeline holds only when it has a result to hand
  // over and the output register cannot take it.
  logic  out_valid_q;
  comp_t out_n_q [3];
  comp_t out_t_q [3];
  comp_t out_c_q [3];
  logic  out_fb_q;

  assign out_load   = !out_valid_q || out_ready_i;
  assign adv        = !u2_valid || out_load;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= u2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_n_q  <= u2_n;
      out_t_q  <= u2_t;
      out_c_q  <= u2_c;
      out_fb_q <= u2_fb;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign col0_x_o        = out_n_q[0];
  assign col0_y_o        = out_n_q[1];
  assign col0_z_o        = out_n_q[2];
  assign col1_x_o        = out_t_q[0];
  assign col1_y_o        = out_t_q[1];
  assign col1_z_o        = out_t_q[2];
  assign col2_x_o        = out_c_q[0];
  assign col2_y_o        = out_c_q[1];
  assign col2_z_o        = out_c_q[2];
  assign fallback_used_o = out_fb_q;

endmodule
